@@ rtl/ihf_pkg.sv @@
// ============================================================================
// ihf_pkg: shared types and constants of the IPv4 header fragmenter
// Item structs of both channels, the command passed from front to back, and
// the fixed header field values.
// ============================================================================
`default_nettype none

package ihf_pkg;

    localparam int LEN_W = 12;
    localparam int SUM_W = 20;
    localparam int IDX_W = 5;

    localparam logic [7:0]  HDR_BYTES   = 8'd20;
    localparam logic [4:0]  HDR_LAST    = 5'd19;
    localparam logic [11:0] WHOLE_LIMIT = 12'd30;
    localparam logic [4:0]  FRAG_LAST   = 5'd23;
    localparam logic [12:0] FRAG_BYTES  = 13'd24;
    localparam logic [7:0]  FRAG_TOTAL  = 8'd44;
    localparam logic [15:0] MF_FLAG     = 16'h2000;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TOS         = 8'h00;
    localparam logic [7:0]  TTL         = 8'h01;
    localparam logic [7:0]  PROTO_TCP   = 8'h06;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] packet_length;
        logic [31:0]      dest_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
        logic       end_of_packet;
    } t_out_item;

    // One payload byte with the header that goes before or after it
    typedef struct packed {
        logic [7:0]       data;
        logic             eof;
        logic             eop;
        logic             hdr_lead;
        logic             hdr_trail;
        logic [7:0]       total;
        logic [15:0]      ident;
        logic [15:0]      flagoff;
        logic [31:0]      dest;
        logic [SUM_W-1:0] sum;
    } t_cmd;

    typedef enum logic [1:0] {
        P_IDLE,
        P_LEAD,
        P_DATA,
        P_TRAIL
    } t_bphase;

endpackage

`default_nettype wire

@@ rtl/ihf_queue.sv @@
// ============================================================================
// ihf_queue: command queue between front and back
// Small register queue; the head is visible while the queue is not empty.
// ============================================================================
`default_nettype none

module ihf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ihf_pkg::t_cmd i_push_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output ihf_pkg::t_cmd      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ihf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ihf_front.sv @@
// ============================================================================
// ihf_front: packet tracking and byte classification
// Latches length and destination on the first byte, tracks the fragment
// position and builds one command per payload byte, with header fields and
// the raw checksum sum of the header it carries.
// ============================================================================
`default_nettype none

module ihf_front #(
    parameter int MAX_LEN    = 2048,
    parameter int IDENT_WRAP = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ihf_pkg::t_in_item i_in,
    input  wire logic [31:0]      i_src_addr,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output ihf_pkg::t_cmd         o_cmd
);

    localparam int LW = ihf_pkg::LEN_W;

    logic [LW-1:0] r_pos;
    logic [LW-1:0] r_len;
    logic [31:0]   r_dest;
    logic [LW-1:0] r_base;
    logic [4:0]    r_within;
    logic [7:0]    r_frag;
    logic [15:0]   r_ident;

    logic          first;
    logic [LW-1:0] eff_len;
    logic [31:0]   eff_dest;
    logic          drop;
    logic          accept;
    logic [12:0]   frag_end;
    logic          in_full;
    logic [9:0]    off_cur;
    logic [9:0]    off_next;
    logic          done;
    logic [LW-1:0] rest;
    ihf_pkg::t_cmd cmd;

    assign first    = (r_pos == '0);
    assign eff_len  = first ? i_in.packet_length : r_len;
    assign eff_dest = first ? i_in.dest_address : r_dest;
    assign drop     = first && ((eff_len == '0) || (32'(eff_len) > MAX_LEN));
    assign o_in_stall = i_q_full;
    assign accept   = i_in_valid && !i_q_full;
    assign frag_end = {1'b0, r_base} + ihf_pkg::FRAG_BYTES;
    assign in_full  = (frag_end <= {1'b0, eff_len});
    assign off_cur  = {1'b0, r_frag, 1'b0} + {2'b00, r_frag};
    assign off_next = off_cur + 10'd3;
    assign rest     = eff_len - r_base;

    always_comb begin
        cmd           = '0;
        cmd.data      = i_in.payload_byte;
        cmd.dest      = eff_dest;
        cmd.ident     = r_ident;
        done          = 1'b0;
        if (eff_len <= ihf_pkg::WHOLE_LIMIT) begin
            done         = (r_pos + 1'b1 == eff_len);
            cmd.hdr_lead = first;
            cmd.total    = ihf_pkg::HDR_BYTES + eff_len[7:0];
            cmd.flagoff  = '0;
            cmd.eof      = done;
            cmd.eop      = done;
        end else if (in_full) begin
            cmd.hdr_lead = (r_within == '0);
            cmd.eof      = (r_within == ihf_pkg::FRAG_LAST);
            cmd.hdr_trail = cmd.eof && (frag_end == {1'b0, eff_len});
            done         = cmd.hdr_trail;
            if (cmd.hdr_trail) begin
                // empty last fragment follows this byte
                cmd.total   = ihf_pkg::HDR_BYTES;
                cmd.flagoff = 16'(off_next);
            end else begin
                cmd.total   = ihf_pkg::FRAG_TOTAL;
                cmd.flagoff = ihf_pkg::MF_FLAG | 16'(off_cur);
            end
        end else begin
            done         = (r_pos + 1'b1 == eff_len);
            cmd.hdr_lead = (r_within == '0);
            cmd.total    = ihf_pkg::HDR_BYTES + rest[7:0];
            cmd.flagoff  = 16'(off_cur);
            cmd.eof      = done;
            cmd.eop      = done;
        end
        cmd.sum = ihf_pkg::SUM_W'({ihf_pkg::VER_IHL, ihf_pkg::TOS})
                + ihf_pkg::SUM_W'(cmd.total)
                + ihf_pkg::SUM_W'(cmd.ident)
                + ihf_pkg::SUM_W'(cmd.flagoff)
                + ihf_pkg::SUM_W'({ihf_pkg::TTL, ihf_pkg::PROTO_TCP})
                + ihf_pkg::SUM_W'(i_src_addr[31:16])
                + ihf_pkg::SUM_W'(i_src_addr[15:0])
                + ihf_pkg::SUM_W'(eff_dest[31:16])
                + ihf_pkg::SUM_W'(eff_dest[15:0]);
    end

    assign o_push = accept && !drop;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_dest   <= '0;
            r_base   <= '0;
            r_within <= '0;
            r_frag   <= '0;
            r_ident  <= '0;
        end else if (o_push) begin
            if (first) begin
                r_len  <= eff_len;
                r_dest <= eff_dest;
            end
            if (done) begin
                r_pos    <= '0;
                r_base   <= '0;
                r_within <= '0;
                r_frag   <= '0;
                r_ident  <= (32'(r_ident) == IDENT_WRAP - 1) ? '0 : r_ident + 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (r_within == ihf_pkg::FRAG_LAST) begin
                    r_within <= '0;
                    r_base   <= frag_end[LW-1:0];
                    r_frag   <= r_frag + 1'b1;
                end else begin
                    r_within <= r_within + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ihf_back.sv @@
// ============================================================================
// ihf_back: frame byte sequencer
// Pops commands and sends header and payload bytes through a registered
// output stage, one byte per cycle unless stalled or the queue runs empty.
// ============================================================================
`default_nettype none

module ihf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire ihf_pkg::t_cmd i_head,
    output logic               o_pop,
    input  wire logic [31:0]   i_src_addr,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ihf_pkg::t_out_item o_out
);

    localparam int IW = ihf_pkg::IDX_W;

    ihf_pkg::t_bphase   r_phase;
    ihf_pkg::t_bphase   n_phase;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;
    ihf_pkg::t_cmd      r_cur;
    ihf_pkg::t_cmd      n_cur;
    logic               r_ov;
    ihf_pkg::t_out_item r_out;

    logic               adv;
    logic               emit;
    ihf_pkg::t_out_item item;

    function automatic logic [7:0] hdr_byte(input ihf_pkg::t_cmd c,
                                            input logic [IW-1:0] idx,
                                            input logic [31:0] src);
        logic [16:0] f1;
        logic [15:0] f2;
        logic [15:0] csum;
        logic [15:0] word;
        begin
            // fold the end-around carries, then complement
            f1   = {1'b0, c.sum[15:0]} + 17'(c.sum[ihf_pkg::SUM_W-1:16]);
            f2   = f1[15:0] + 16'(f1[16]);
            csum = ~f2;
            case (idx[IW-1:1])
                4'd0:    word = {ihf_pkg::VER_IHL, ihf_pkg::TOS};
                4'd1:    word = 16'(c.total);
                4'd2:    word = c.ident;
                4'd3:    word = c.flagoff;
                4'd4:    word = {ihf_pkg::TTL, ihf_pkg::PROTO_TCP};
                4'd5:    word = csum;
                4'd6:    word = src[31:16];
                4'd7:    word = src[15:0];
                4'd8:    word = c.dest[31:16];
                4'd9:    word = c.dest[15:0];
                default: word = '0;
            endcase
            hdr_byte = idx[0] ? word[7:0] : word[15:8];
        end
    endfunction

    assign adv = !r_ov || !i_out_stall;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_cur   = r_cur;
        o_pop   = 1'b0;
        emit    = 1'b0;
        item    = '0;
        if (adv) begin
            unique case (r_phase)
                ihf_pkg::P_IDLE: begin
                    if (!i_q_empty) begin
                        o_pop = 1'b1;
                        emit  = 1'b1;
                        n_cur = i_head;
                        if (i_head.hdr_lead) begin
                            item.out_byte = hdr_byte(i_head, '0, i_src_addr);
                            n_phase = ihf_pkg::P_LEAD;
                            n_idx   = IW'(1);
                        end else begin
                            item.out_byte      = i_head.data;
                            item.end_of_frame  = i_head.eof;
                            item.end_of_packet = i_head.eop;
                            if (i_head.hdr_trail) begin
                                n_phase = ihf_pkg::P_TRAIL;
                                n_idx   = '0;
                            end
                        end
                    end
                end
                ihf_pkg::P_LEAD: begin
                    emit = 1'b1;
                    item.out_byte = hdr_byte(r_cur, r_idx, i_src_addr);
                    n_idx = r_idx + 1'b1;
                    if (r_idx == ihf_pkg::HDR_LAST) begin
                        n_phase = ihf_pkg::P_DATA;
                    end
                end
                ihf_pkg::P_DATA: begin
                    emit = 1'b1;
                    item.out_byte      = r_cur.data;
                    item.end_of_frame  = r_cur.eof;
                    item.end_of_packet = r_cur.eop;
                    n_idx   = '0;
                    n_phase = r_cur.hdr_trail ? ihf_pkg::P_TRAIL : ihf_pkg::P_IDLE;
                end
                ihf_pkg::P_TRAIL: begin
                    emit = 1'b1;
                    item.out_byte = hdr_byte(r_cur, r_idx, i_src_addr);
                    n_idx = r_idx + 1'b1;
                    if (r_idx == ihf_pkg::HDR_LAST) begin
                        // the empty last fragment closes the packet
                        item.end_of_frame  = 1'b1;
                        item.end_of_packet = 1'b1;
                        n_phase = ihf_pkg::P_IDLE;
                    end
                end
                default: n_phase = ihf_pkg::P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ihf_pkg::P_IDLE;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (adv) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (adv && emit) begin
            r_out <= item;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ rtl/ipv4_header_fragmenter.sv @@
// ============================================================================
// ipv4_header_fragmenter: IPv4 header insertion and fragmentation
// Turns a stream of payload bytes into IPv4 frames, byte by byte.
// ============================================================================
// Input channel (i_in_valid / o_in_stall) takes one payload byte per transfer
// with the packet length and destination, read on the first byte of a packet.
// A first byte with length zero or above MAX_LEN is taken and dropped.
// Output channel (o_out_valid / i_out_stall) gives one frame byte per transfer
// with end-of-frame and end-of-packet marks. Packets of up to 30 bytes go out
// as one frame; longer ones as 24-byte fragments plus a last fragment.
// The config channel (i_cfg_valid / o_cfg_ready, always ready) sets the
// source address; write it only while the block is idle.
// Each byte's command passes the queue, then a registered output stage. One
// output byte per cycle while i_out_stall is low and work is queued; a payload
// byte that opens a frame goes out behind its 20 header bytes, so a full
// fragment of 24 bytes gives 44 output bytes. A four-entry command queue
// lets input transfers continue while the output sends a header or is
// stalled; when it fills, o_in_stall rises. Reset clears the packet position,
// identification counter and source address; no clearing pass is needed.
// ============================================================================
`default_nettype none

module ipv4_header_fragmenter #(
    parameter int MAX_LEN     = 2048,
    parameter int IDENT_WRAP  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ihf_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ihf_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [31:0]       i_cfg_data
);

    logic [31:0]   r_local_ip;
    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    ihf_pkg::t_cmd push_cmd;
    ihf_pkg::t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_ip <= i_cfg_data;
        end
    end

    ihf_front #(
        .MAX_LEN    (MAX_LEN),
        .IDENT_WRAP (IDENT_WRAP)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_src_addr (r_local_ip),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    ihf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_head      (head_cmd)
    );

    ihf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .i_src_addr  (r_local_ip),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
